/* sv/cwcmi_pkg.sv */
// Shared widths, register codes and the cool-to-warm color ROM
// for the colormap interpolator. No dependencies.
package cwcmi_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int RATIO_W       = 16;
   localparam int CHAN_W        = 8;
   localparam int RGB_W         = 3 * CHAN_W;
   localparam int TABLE_ENTRIES = 33;
   localparam int ROM_ROWS      = 33;
   localparam int IDX_W         = $clog2(ROM_ROWS);

   // position scale 31.999 in Q6.16, (TABLE_ENTRIES - 1) * 2^16 - 66
   localparam int SCALE_W = $clog2((TABLE_ENTRIES - 1) * 65536) + 1;
   localparam logic [SCALE_W-1:0] SCALE_Q16 =
      SCALE_W'((TABLE_ENTRIES - 1) * 65536 - 66);
   localparam int POS_W  = RATIO_W + SCALE_W;
   localparam int PIDX_W = POS_W - 32;

   localparam int FRAC_W = 17;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam int ACC_W  = CHAN_W + FRAC_W;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALUE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE = 2'd1;
   localparam logic [SAMPLE_W-1:0]  MIN_RESET     = 16'd1;
   localparam logic [SAMPLE_W-1:0]  MAX_RESET     = 16'd400;

   // entries packed {red, green, blue}
   localparam logic [RGB_W-1:0] CW_ROM [ROM_ROWS] = '{
      {8'd59,  8'd76,  8'd192}, {8'd68,  8'd90,  8'd204},
      {8'd77,  8'd104, 8'd215}, {8'd87,  8'd117, 8'd225},
      {8'd98,  8'd130, 8'd234}, {8'd108, 8'd142, 8'd241},
      {8'd119, 8'd154, 8'd247}, {8'd130, 8'd165, 8'd251},
      {8'd141, 8'd176, 8'd254}, {8'd152, 8'd185, 8'd255},
      {8'd163, 8'd194, 8'd255}, {8'd174, 8'd201, 8'd253},
      {8'd184, 8'd208, 8'd249}, {8'd194, 8'd213, 8'd244},
      {8'd204, 8'd217, 8'd238}, {8'd213, 8'd219, 8'd230},
      {8'd221, 8'd221, 8'd221}, {8'd229, 8'd216, 8'd209},
      {8'd236, 8'd211, 8'd197}, {8'd241, 8'd204, 8'd185},
      {8'd245, 8'd196, 8'd173}, {8'd247, 8'd187, 8'd160},
      {8'd247, 8'd177, 8'd148}, {8'd247, 8'd166, 8'd135},
      {8'd244, 8'd154, 8'd123}, {8'd241, 8'd141, 8'd111},
      {8'd236, 8'd127, 8'd99},  {8'd229, 8'd112, 8'd88},
      {8'd222, 8'd96,  8'd77},  {8'd213, 8'd80,  8'd66},
      {8'd203, 8'd62,  8'd56},  {8'd192, 8'd40,  8'd47},
      {8'd180, 8'd4,   8'd38}
   };

endpackage

/* sv/cool_warm_colormap_interpolator_unit.sv */
// Cool-to-warm pseudocolor interpolator: clamp, restoring divide, scale,
// ROM lookup and linear blend in a 20-stage pipeline. Uses cwcmi_pkg.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready | req_tdata: sample_value[15:0]
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: red, green, blue
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data[15:0]
//
// One word enters per cycle unless a full pipeline is held by rsp_tready low.
// The depth is set by the ratio divider, one quotient bit per stage.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and req_tready stays high while any stage is free.
// Synchronous active-high reset clears the valid bits and loads min 1, max 400.
module cool_warm_colormap_interpolator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cwcmi_pkg::SAMPLE_W-1:0]    req_tdata,   // [15:0] sample_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cwcmi_pkg::RGB_W-1:0]       rsp_tdata,   // [7:0] red, [15:8] green,
                                                          // [23:16] blue
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cwcmi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cwcmi_pkg::SAMPLE_W-1:0]    csr_data
);

   localparam int SW      = cwcmi_pkg::SAMPLE_W;
   localparam int STEPS   = cwcmi_pkg::RATIO_W;
   localparam int NUM_STG = STEPS + 4;
   localparam int MUL_STG = STEPS + 1;
   localparam int LUT_STG = STEPS + 2;
   localparam int CW      = cwcmi_pkg::CHAN_W;

   // configuration
   logic [SW-1:0] min_ff;
   logic [SW-1:0] max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= cwcmi_pkg::MIN_RESET;
         max_ff <= cwcmi_pkg::MAX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cwcmi_pkg::CSR_MIN_VALUE: min_ff <= csr_data;
            cwcmi_pkg::CSR_MAX_VALUE: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NUM_STG-1:0] valid_ff;
   logic [NUM_STG-1:0] valid_in;
   logic [NUM_STG-1:0] adv;

   always_comb begin
      adv[NUM_STG-1] = !valid_ff[NUM_STG-1] || rsp_tready;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[NUM_STG-1];

   // stage 0: clamp and offset
   logic [SW-1:0] clamp_in;
   logic [SW-1:0] d0_in;
   logic [SW-1:0] span0_in;
   logic          rng0_in;
   logic [SW-1:0] d0_ff;
   logic [SW-1:0] span0_ff;
   logic          rng0_ff;
   logic          full0_ff;

   always_comb begin
      rng0_in  = max_ff > min_ff;
      span0_in = max_ff - min_ff;
      if (req_tdata < min_ff) begin
         clamp_in = min_ff;
      end else if (req_tdata > max_ff) begin
         clamp_in = max_ff;
      end else begin
         clamp_in = req_tdata;
      end
      d0_in = rng0_in ? clamp_in - min_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d0_ff    <= d0_in;
         span0_ff <= span0_in;
         rng0_ff  <= rng0_in;
         full0_ff <= rng0_in && (d0_in == span0_in);
      end
   end

   // stages 1..16: restoring divide of d * 2^16 by span, one bit per stage
   logic [SW-1:0]      rem_ff  [STEPS];
   logic [STEPS-1:0]   quo_ff  [STEPS];
   logic [SW-1:0]      span_ff [STEPS];
   logic               rng_ff  [STEPS];
   logic               full_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_div
      logic [SW-1:0]    rem_prev;
      logic [STEPS-1:0] quo_prev;
      logic [SW-1:0]    span_prev;
      logic             rng_prev;
      logic             full_prev;
      logic [SW:0]      dbl;
      logic             take;
      logic [SW-1:0]    rem_in;

      if (k == 0) begin : g_first
         assign rem_prev  = d0_ff;
         assign quo_prev  = '0;
         assign span_prev = span0_ff;
         assign rng_prev  = rng0_ff;
         assign full_prev = full0_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign span_prev = span_ff[k-1];
         assign rng_prev  = rng_ff[k-1];
         assign full_prev = full_ff[k-1];
      end

      always_comb begin
         dbl    = {rem_prev, 1'b0};
         take   = dbl >= {1'b0, span_prev};
         rem_in = take ? SW'(dbl - {1'b0, span_prev}) : dbl[SW-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv[k+1]) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= {quo_prev[STEPS-2:0], take};
            span_ff[k] <= span_prev;
            rng_ff[k]  <= rng_prev;
            full_ff[k] <= full_prev;
         end
      end
   end

   // ratio select and position multiply
   logic [STEPS-1:0]              ratio;
   logic [cwcmi_pkg::POS_W-1:0]   pos_ff;

   always_comb begin
      if (!rng_ff[STEPS-1]) begin
         ratio = '0;
      end else if (full_ff[STEPS-1]) begin
         ratio = '1;
      end else begin
         ratio = quo_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[MUL_STG]) begin
         pos_ff <= cwcmi_pkg::POS_W'(ratio) * cwcmi_pkg::POS_W'(cwcmi_pkg::SCALE_Q16);
      end
   end

   // table lookup of the two neighbor entries
   logic [cwcmi_pkg::PIDX_W-1:0]  pidx;
   logic                          sat;
   logic [cwcmi_pkg::IDX_W-1:0]   lo_idx;
   logic [cwcmi_pkg::FRAC_W-1:0]  frac_in;
   logic [cwcmi_pkg::RGB_W-1:0]   lo_rgb_ff;
   logic [cwcmi_pkg::RGB_W-1:0]   hi_rgb_ff;
   logic [cwcmi_pkg::FRAC_W-1:0]  frac_ff;

   always_comb begin
      pidx = pos_ff[cwcmi_pkg::POS_W-1:32];
      sat  = pidx > cwcmi_pkg::PIDX_W'(cwcmi_pkg::ROM_ROWS - 2);
      // index past the stored rows: pin to the last entry
      lo_idx  = sat ? cwcmi_pkg::IDX_W'(cwcmi_pkg::ROM_ROWS - 2)
                    : cwcmi_pkg::IDX_W'(pidx);
      frac_in = sat ? cwcmi_pkg::FRAC_ONE : {1'b0, pos_ff[31:16]};
   end

   always_ff @(posedge clock) begin
      if (adv[LUT_STG]) begin
         lo_rgb_ff <= cwcmi_pkg::CW_ROM[lo_idx];
         hi_rgb_ff <= cwcmi_pkg::CW_ROM[lo_idx + cwcmi_pkg::IDX_W'(1)];
         frac_ff   <= frac_in;
      end
   end

   // blend and round each channel; blue is the low byte of a ROM entry
   logic [cwcmi_pkg::FRAC_W-1:0] inv_frac;
   logic [cwcmi_pkg::RGB_W-1:0]  rgb_in;

   always_comb begin
      inv_frac = cwcmi_pkg::FRAC_ONE - frac_ff;
      for (int c = 0; c < 3; c++) begin
         logic [cwcmi_pkg::ACC_W-1:0] acc;
         acc = cwcmi_pkg::ACC_W'(lo_rgb_ff[(2-c)*CW +: CW]) * cwcmi_pkg::ACC_W'(inv_frac)
             + cwcmi_pkg::ACC_W'(hi_rgb_ff[(2-c)*CW +: CW]) * cwcmi_pkg::ACC_W'(frac_ff)
             + cwcmi_pkg::ROUND_HALF;
         rgb_in[c*CW +: CW] = acc[16 +: CW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STG-1]) begin
         rsp_tdata <= rgb_in;
      end
   end

endmodule

/* sv/cwcmi_checker.sv */
// Port-level checks for cool_warm_colormap_interpolator_unit, attached by bind.
// Depends on cwcmi_pkg for port widths.
module cwcmi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cwcmi_pkg::RGB_W-1:0]       rsp_tdata
);

   // no word may come out of a pipeline just cleared
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // with the output stage empty the whole pipeline can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low while output stage is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

endmodule

bind cool_warm_colormap_interpolator_unit cwcmi_checker u_cwcmi_checker (.*);
